FILE: rtl/core/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT    = 16'hFFFD;
    localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW_BOUND = 21'h00D800;
    localparam logic [20:0] SURR_HIGH_BOUND = 21'h00DFFF;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] PLANE_ONE      = 21'h010000;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [20:0] point;
        logic [1:0]  pending;
    } t_dec_state;

    // Code units produced by one byte (0, 1 or 2)
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_dec_result;

endpackage

FILE: rtl/core/u8u16_in_if.sv
// Byte input channel: valid/ready handshake with one UTF-8 byte.
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

FILE: rtl/core/u8u16_out_if.sv
// Code unit output channel: valid/ready handshake with one UTF-16 unit.
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_last;
    logic        unit_is_final;

    modport source (output valid, output code_unit, output run_last,
                    output unit_is_final, input ready);
    modport sink (input valid, input code_unit, input run_last,
                  input unit_is_final, output ready);
endinterface

FILE: rtl/core/u8u16_decode.sv
// Combinational decode of one UTF-8 byte against the open sequence state.
module u8u16_decode (
    input  u8u16_pkg::t_dec_state  i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_end,
    output u8u16_pkg::t_dec_state  o_next,
    output u8u16_pkg::t_dec_result o_res
);
    import u8u16_pkg::*;

    logic        cont;
    logic        open_seq;
    logic [20:0] acc_point;
    logic [1:0]  pend_dec;

    logic        lead_n;
    logic        lead_open;
    logic [15:0] lead_unit;
    logic [20:0] lead_point;
    logic [1:0]  lead_pend;

    logic        bad_point;
    logic [20:0] fixed_point;
    logic        two_units;
    logic [20:0] offset;
    logic [15:0] high_unit;
    logic [15:0] low_unit;

    assign cont      = (i_byte[7:6] == 2'b10);
    assign open_seq  = (i_state.pending != 2'd0);
    assign acc_point = {i_state.point[14:0], i_byte[5:0]};
    assign pend_dec  = i_state.pending - 2'd1;

    // Lead byte classification
    always_comb begin
        lead_n     = 1'b0;
        lead_open  = 1'b0;
        lead_unit  = REPLACEMENT;
        lead_point = '0;
        lead_pend  = 2'd0;
        priority if (i_byte[7] == 1'b0) begin
            lead_n    = 1'b1;
            lead_unit = {8'h00, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            lead_open  = 1'b1;
            lead_point = {16'h0000, i_byte[4:0]};
            lead_pend  = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_open  = 1'b1;
            lead_point = {17'h00000, i_byte[3:0]};
            lead_pend  = 2'd2;
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_open  = 1'b1;
            lead_point = {18'h00000, i_byte[2:0]};
            lead_pend  = 2'd3;
        end else begin
            lead_n    = 1'b1;
            lead_unit = REPLACEMENT;
        end
        // sequence opened on the last byte of the string is cut off
        if (lead_open && i_end) begin
            lead_n    = 1'b1;
            lead_unit = REPLACEMENT;
        end
    end

    // Completed code point to UTF-16
    assign bad_point   = (acc_point > MAX_POINT) ||
                         ((acc_point >= SURR_LOW_BOUND) && (acc_point <= SURR_HIGH_BOUND));
    assign fixed_point = bad_point ? {5'b00000, REPLACEMENT} : acc_point;
    assign two_units   = (fixed_point[20:16] != 5'd0);
    assign offset      = fixed_point - PLANE_ONE;
    assign high_unit   = HIGH_SURR_BASE + {6'b000000, offset[19:10]};
    assign low_unit    = LOW_SURR_BASE + {6'b000000, offset[9:0]};

    always_comb begin
        o_next       = '0;
        o_res.count  = 2'd0;
        o_res.unit0  = REPLACEMENT;
        o_res.unit1  = REPLACEMENT;
        if (open_seq && cont) begin
            if (pend_dec == 2'd0) begin
                o_res.count = two_units ? 2'd2 : 2'd1;
                o_res.unit0 = two_units ? high_unit : fixed_point[15:0];
                o_res.unit1 = low_unit;
            end else if (i_end) begin
                o_res.count = 2'd1;
            end else begin
                o_next.point   = acc_point;
                o_next.pending = pend_dec;
            end
        end else if (open_seq) begin
            // broken sequence: replacement, then the byte again as a lead
            o_res.count = 2'd1 + {1'b0, lead_n};
            o_res.unit1 = lead_unit;
            if (lead_open && !i_end) begin
                o_next.point   = lead_point;
                o_next.pending = lead_pend;
            end
        end else begin
            o_res.count = {1'b0, lead_n};
            o_res.unit0 = lead_unit;
            if (lead_open && !i_end) begin
                o_next.point   = lead_point;
                o_next.pending = lead_pend;
            end
        end
    end

endmodule

FILE: rtl/core/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder.
//
// i_in carries one UTF-8 byte per transaction with string_end marking the
// last byte of a string. o_out carries one UTF-16 code unit per transaction;
// run_last marks the last unit caused by a byte, unit_is_final the last unit
// of the whole string. A byte gives zero, one or two units.
// Units are registered: a byte accepted on i_in shows its first unit on o_out
// in the next cycle. Throughput: one byte per cycle while each byte gives at most
// one unit and the receiver takes each unit; a byte that gives two units (surrogate
// pair, or a replacement followed by a redecoded lead) holds i_in.ready low
// until its first unit has left the two-entry result register.
// A new byte is taken in the cycle the last buffered unit leaves.
// Reset clears the open sequence and empties the result register.
// When the receiver stalls, the buffered units hold and i_in.ready drops
// until the last of them is taken; no unit is lost or repeated.
module utf8_to_utf16_decoder (
    input logic         i_clk,
    input logic         i_rst_n,
    u8u16_in_if.sink    i_in,
    u8u16_out_if.source o_out
);
    import u8u16_pkg::*;

    t_dec_state  r_state;
    t_dec_state  dec_next;
    t_dec_result dec_res;

    logic [1:0]  r_cnt;
    logic [15:0] r_unit0;
    logic [15:0] r_unit1;
    logic        r_end;

    logic        in_acc;
    logic        out_acc;

    u8u16_decode u_decode (
        .i_state (r_state),
        .i_byte  (i_in.in_byte),
        .i_end   (i_in.string_end),
        .o_next  (dec_next),
        .o_res   (dec_res)
    );

    assign out_acc    = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.code_unit     = r_unit0;
    assign o_out.run_last      = (r_cnt == 2'd1);
    assign o_out.unit_is_final = (r_cnt == 2'd1) && r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= 2'd0;
        end else if (in_acc) begin
            r_state <= dec_next;
            r_cnt   <= dec_res.count;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_unit0 <= dec_res.unit0;
            r_unit1 <= dec_res.unit1;
            r_end   <= i_in.string_end;
        end else if (out_acc) begin
            r_unit0 <= r_unit1;
        end
    end

endmodule

FILE: tb/sv/utf8_to_utf16_decoder_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder: directed and random byte streams.
module utf8_to_utf16_decoder_tb;
    import u8u16_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1350;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_text_byte;

    typedef struct packed {
        logic [15:0] unit;
        logic        run_last;
        logic        is_final;
    } t_code_unit;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8u16_in_if  byte_if ();
    u8u16_out_if unit_if ();

    utf8_to_utf16_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (unit_if)
    );

    always #2 i_clk = ~i_clk;

    t_text_byte  text_q[$];
    t_code_unit  units_due[$];
    logic [15:0] step_units[$];

    // decoder state mirrored by the predictor
    logic [20:0] acc_point;
    logic [1:0]  acc_left;

    int unsigned error_count = 0;
    int unsigned bytes_taken = 0;
    int unsigned idle_cycles = 0;
    bit          timed_out = 0;
    bit          in_calm = 0;
    bit          out_calm = 0;
    int unsigned in_gap = 0;
    int unsigned out_wait = 0;
    bit          in_held;
    logic        hold_off;
    t_text_byte  next_byte;
    t_code_unit  want;

    function automatic int unsigned pause_len(input bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void close_seq();
        acc_point = '0;
        acc_left  = '0;
    endfunction

    // append one predicted unit for the current byte
    function automatic void emit_unit(input logic [15:0] u);
        step_units.insert(step_units.size(), u);
    endfunction

    // byte taken with no sequence open (or after a broken one)
    function automatic void start_lead(input logic [7:0] b, input logic fin);
        if (b[7] == 1'b0) begin
            emit_unit({8'h00, b});
        end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
            emit_unit(REPLACEMENT);
        end else begin
            if (b[7:5] == 3'b110) begin
                acc_point = {16'd0, b[4:0]};
                acc_left  = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                acc_point = {17'd0, b[3:0]};
                acc_left  = 2'd2;
            end else begin
                acc_point = {18'd0, b[2:0]};
                acc_left  = 2'd3;
            end
            if (fin) begin
                close_seq();
                emit_unit(REPLACEMENT);
            end
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [20:0] cp;
        int          n;
        step_units.delete();
        if (acc_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                acc_point = {acc_point[14:0], b[5:0]};
                acc_left  = acc_left - 2'd1;
                if (acc_left == 2'd0) begin
                    cp = acc_point;
                    if (cp > MAX_POINT || (cp >= SURR_LOW_BOUND && cp <= SURR_HIGH_BOUND))
                        cp = {5'd0, REPLACEMENT};
                    if (cp <= 21'h00FFFF) begin
                        emit_unit(cp[15:0]);
                    end else begin
                        cp = cp - PLANE_ONE;
                        emit_unit(HIGH_SURR_BASE + {6'd0, cp[19:10]});
                        emit_unit(LOW_SURR_BASE + {6'd0, cp[9:0]});
                    end
                    close_seq();
                end else if (fin) begin
                    close_seq();
                    emit_unit(REPLACEMENT);
                end
            end else begin
                close_seq();
                emit_unit(REPLACEMENT);
                start_lead(b, fin);
            end
        end else begin
            start_lead(b, fin);
        end
        if (fin)
            close_seq();
        n = step_units.size();
        for (int i = 0; i < n; i++)
            units_due.insert(units_due.size(),
                             '{step_units[i], i == n - 1, (i == n - 1) && fin});
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic fin);
        text_q.insert(text_q.size(), '{b, fin});
    endtask

    // one character, mostly well formed; sometimes cut short or followed by noise
    task automatic add_char();
        int unsigned len;
        int unsigned keep;
        logic [7:0]  seq [4];
        len = $urandom_range(1, 4);
        case (len)
            1: seq[0] = 8'($urandom_range(0, 127));
            2: seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
            3: seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
            default: seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        for (int i = 1; i < 4; i++)
            seq[i] = 8'h80 | 8'($urandom_range(0, 63));
        keep = len;
        if (len > 1 && $urandom_range(0, 9) == 0)
            keep = $urandom_range(1, len - 1);
        for (int i = 0; i < keep; i++)
            add_byte(seq[i], (i == keep - 1 && $urandom_range(0, 7) == 0) ||
                             $urandom_range(0, 39) == 0);
        if ($urandom_range(0, 9) == 0)
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    endtask

    // byte sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
            in_gap = 0;
        end else begin
            in_held = byte_if.valid;
            if (byte_if.valid && byte_if.ready) begin
                in_held = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    in_calm = ~in_calm;
                in_gap = pause_len(in_calm);
            end
            if (!in_held) begin
                if (in_gap == 0 && text_q.size() != 0) begin
                    next_byte = text_q.pop_front();
                    byte_if.valid      <= 1'b1;
                    byte_if.in_byte    <= next_byte.value;
                    byte_if.string_end <= next_byte.last;
                end else begin
                    byte_if.valid <= 1'b0;
                    if (in_gap != 0)
                        in_gap--;
                end
            end
        end
    end

    // unit receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            unit_if.ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (unit_if.valid && unit_if.ready) begin
                if ($urandom_range(0, 39) == 0)
                    out_calm = ~out_calm;
                out_wait = pause_len(out_calm);
            end
            if (out_wait != 0) begin
                unit_if.ready <= 1'b0;
                out_wait--;
            end else begin
                unit_if.ready <= !hold_off;
            end
        end
    end

    // long receiver stall once the stream is well under way
    initial begin
        while (bytes_taken < 500)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // prediction, checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                decode_byte(byte_if.in_byte, byte_if.string_end);
                bytes_taken++;
            end
            if (unit_if.valid && unit_if.ready) begin
                if (units_due.size() == 0) begin
                    $error("code_unit: expected none, got %h", unit_if.code_unit);
                    error_count++;
                end else begin
                    want = units_due.pop_front();
                    if (unit_if.code_unit !== want.unit) begin
                        $error("code_unit: expected %h, got %h", want.unit, unit_if.code_unit);
                        error_count++;
                    end
                    if (unit_if.run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, unit_if.run_last);
                        error_count++;
                    end
                    if (unit_if.unit_is_final !== want.is_final) begin
                        $error("unit_is_final: expected %b, got %b",
                               want.is_final, unit_if.unit_is_final);
                        error_count++;
                    end
                end
            end
            if ((byte_if.valid && byte_if.ready) || (unit_if.valid && unit_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial begin
        byte_if.valid      = 1'b0;
        byte_if.in_byte    = 8'h00;
        byte_if.string_end = 1'b0;
        unit_if.ready      = 1'b0;
        hold_off           = 1'b0;
        i_rst_n            = 1'b0;
        close_seq();

        // ASCII extremes and an overlong NUL
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        // two, three and four byte forms; the last one needs a surrogate pair
        add_byte(8'hC2, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h9F, 1'b0);
        add_byte(8'h98, 1'b0);
        add_byte(8'h80, 1'b0);
        // above U+10FFFF, then an encoded surrogate
        add_byte(8'hF7, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hED, 1'b0);
        add_byte(8'hA0, 1'b0);
        add_byte(8'h80, 1'b0);
        // stray continuation and bytes that can never lead
        add_byte(8'h80, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'hFF, 1'b0);
        // broken sequences: new lead mid-sequence, ASCII mid-sequence
        add_byte(8'hE2, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b1);
        // sequences cut off by the end of the string
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        add_byte(8'hF4, 1'b1);

        while (text_q.size() < 31 + RANDOM_BYTES)
            add_char();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (!timed_out &&
               !(text_q.size() == 0 && !byte_if.valid && units_due.size() == 0))
            @(negedge i_clk);
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (!timed_out && error_count == 0 && units_due.size() == 0)
            $display("utf8_to_utf16_decoder_tb OK");
        else
            $display("utf8_to_utf16_decoder_tb NOT OK");
        $finish;
    end

endmodule
